// ===== hdl/chacha_pkg.sv =====
package chacha_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int UC_PC_W    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_INIT  = 3'd6;

  localparam logic [WORD_W-1:0] SIGMA [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  // microcode operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QR    = 2'd1;
  localparam logic [1:0] OP_FINAL = 2'd2;
  localparam logic [1:0] OP_EMIT  = 2'd3;

  // rotate amounts
  localparam logic [1:0] ROT16 = 2'd0;
  localparam logic [1:0] ROT12 = 2'd1;
  localparam logic [1:0] ROT8  = 2'd2;
  localparam logic [1:0] ROT7  = 2'd3;

  localparam logic [UC_PC_W-1:0] UC_ENTRY      = 4'd0;
  localparam logic [UC_PC_W-1:0] UC_LOOP_START = 4'd1;

  typedef struct packed {
    logic [1:0] op;
    logic       diag;    // diagonal round instead of column round
    logic       half_c;  // c += d / b ^= c instead of a += b / d ^= a
    logic [1:0] rot;
    logic       loop;    // jump back to loop start while rounds remain
  } uc_word_t;

  function automatic uc_word_t uc_fetch(input logic [UC_PC_W-1:0] pc);
    uc_word_t w;
    unique case (pc)
      4'd0:    w = '{OP_LOAD,  1'b0, 1'b0, ROT16, 1'b0};
      4'd1:    w = '{OP_QR,    1'b0, 1'b0, ROT16, 1'b0};
      4'd2:    w = '{OP_QR,    1'b0, 1'b1, ROT12, 1'b0};
      4'd3:    w = '{OP_QR,    1'b0, 1'b0, ROT8,  1'b0};
      4'd4:    w = '{OP_QR,    1'b0, 1'b1, ROT7,  1'b0};
      4'd5:    w = '{OP_QR,    1'b1, 1'b0, ROT16, 1'b0};
      4'd6:    w = '{OP_QR,    1'b1, 1'b1, ROT12, 1'b0};
      4'd7:    w = '{OP_QR,    1'b1, 1'b0, ROT8,  1'b0};
      4'd8:    w = '{OP_QR,    1'b1, 1'b1, ROT7,  1'b1};
      4'd9:    w = '{OP_FINAL, 1'b0, 1'b0, ROT16, 1'b0};
      default: w = '{OP_EMIT,  1'b0, 1'b0, ROT16, 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] rotl_sel(input logic [WORD_W-1:0] x,
                                                 input logic [1:0] rot);
    logic [WORD_W-1:0] r;
    unique case (rot)
      ROT16:   r = {x[15:0], x[31:16]};
      ROT12:   r = {x[19:0], x[31:20]};
      ROT8:    r = {x[23:0], x[31:24]};
      default: r = {x[24:0], x[31:25]};
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/chacha_if.sv =====
interface chacha_in_if;
  logic                           valid;
  logic                           ready;
  logic [chacha_pkg::BYTE_W-1:0]  data_byte;
  logic                           last_of_message;

  modport source (output valid, data_byte, last_of_message, input ready);
  modport sink   (input valid, data_byte, last_of_message, output ready);
endinterface

interface chacha_out_if;
  logic                           valid;
  logic                           ready;
  logic [chacha_pkg::BYTE_W-1:0]  result_byte;
  logic                           result_last;

  modport source (output valid, result_byte, result_last, input ready);
  modport sink   (input valid, result_byte, result_last, output ready);
endinterface

// ===== hdl/chacha20_stream_cipher_top.sv =====
// chacha20 stream cipher, ietf form with 96-bit nonce, one byte per transaction
// in_if carries a data byte and a last-of-message mark; out_if returns the byte
// xored with the keystream plus a copy of the mark, one result per input.
// cfg_we/cfg_index/cfg_data load key, nonce and initial counter; write only
// while no transaction is in flight. index 7 is ignored.
// a byte in the middle of a 64-byte block is answered on the next cycle and a
// new byte can be taken every cycle while the receiver takes the results.
// the first byte of a block starts the microcode program: one load step,
// 8 * DOUBLE_ROUNDS quarter-round steps (four lanes in parallel, one add per
// lane per step), one final add and one emit step that presents its result;
// no new byte is taken while the program runs.
// after a last-marked byte the next byte restarts at position zero with the
// initial counter. reset clears configuration, counter and position.
// when the receiver stalls, the result is held in the output register and
// in_if.ready stays low until it is taken.
module chacha20_stream_cipher_top #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data,
  chacha_in_if.sink                         in_if,
  chacha_out_if.source                      out_if
);
  import chacha_pkg::*;

  localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

  logic [CFG_DATA_W-1:0] key_r [4];
  logic [CFG_DATA_W-1:0] nonce_lo_r;
  logic [WORD_W-1:0]     nonce_hi_r;
  logic [WORD_W-1:0]     ctr_init_r;
  logic [WORD_W-1:0]     ctr_r;
  logic [POS_W-1:0]      pos_r;
  logic                  start_r;
  logic                  busy_r;
  logic [UC_PC_W-1:0]    step_r;
  logic [RND_W-1:0]      rnd_r;
  logic [WORD_W-1:0]     work_r [16];
  logic [WORD_W-1:0]     work_nxt [16];
  logic [BYTE_W-1:0]     pend_data_r;
  logic                  pend_last_r;
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_data_r;
  logic                  out_last_r;

  uc_word_t              uc;
  logic [WORD_W-1:0]     init_w [16];
  logic [WORD_W-1:0]     sum_w [4];
  logic [3:0]            ia [4];
  logic [3:0]            ib [4];
  logic [3:0]            ic [4];
  logic [3:0]            id [4];
  logic [1:0]            li;
  logic                  in_ready;
  logic                  in_accept;
  logic [POS_W-1:0]      pos_eff;
  logic                  need_block;
  logic [POS_W-1:0]      sel_pos;
  logic [WORD_W-1:0]     ks_word;
  logic [WORD_W-1:0]     ks_shift;
  logic [BYTE_W-1:0]     ks_byte;
  logic                  emit;

  assign uc         = uc_fetch(step_r);
  assign in_ready   = !busy_r && (!out_valid_r || out_if.ready);
  assign in_accept  = in_if.valid && in_ready;
  assign pos_eff    = start_r ? '0 : pos_r;
  assign need_block = (pos_eff == '0);
  assign emit       = busy_r && (uc.op == OP_EMIT);

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.result_byte = out_data_r;
  assign out_if.result_last = out_last_r;

  // keystream byte select, little-endian within each word
  assign sel_pos  = busy_r ? '0 : pos_eff;
  assign ks_word  = work_r[sel_pos[5:2]];
  assign ks_shift = ks_word >> {sel_pos[1:0], 3'b000};
  assign ks_byte  = ks_shift[BYTE_W-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i]         = SIGMA[i];
      init_w[4 + 2*i]   = key_r[i][31:0];
      init_w[5 + 2*i]   = key_r[i][63:32];
    end
    init_w[12] = ctr_r;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  // datapath: four quarter-round lanes, column or diagonal selection
  always_comb begin
    li = '0;
    for (int i = 0; i < 16; i++) begin
      work_nxt[i] = work_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      li    = 2'(i);
      ia[i] = {2'b00, li};
      ib[i] = {2'b01, uc.diag ? 2'(li + 2'd1) : li};
      ic[i] = {2'b10, uc.diag ? 2'(li + 2'd2) : li};
      id[i] = {2'b11, uc.diag ? 2'(li + 2'd3) : li};
      sum_w[i] = uc.half_c ? work_r[ic[i]] + work_r[id[i]]
                           : work_r[ia[i]] + work_r[ib[i]];
    end
    if (busy_r) begin
      unique case (uc.op)
        OP_LOAD: begin
          for (int i = 0; i < 16; i++) begin
            work_nxt[i] = init_w[i];
          end
        end
        OP_QR: begin
          for (int i = 0; i < 4; i++) begin
            if (uc.half_c) begin
              work_nxt[ic[i]] = sum_w[i];
              work_nxt[ib[i]] = rotl_sel(work_r[ib[i]] ^ sum_w[i], uc.rot);
            end else begin
              work_nxt[ia[i]] = sum_w[i];
              work_nxt[id[i]] = rotl_sel(work_r[id[i]] ^ sum_w[i], uc.rot);
            end
          end
        end
        OP_FINAL: begin
          for (int i = 0; i < 16; i++) begin
            work_nxt[i] = work_r[i] + init_w[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      work_r[i] <= work_nxt[i];
    end
    if (in_accept) begin
      pend_data_r <= in_if.data_byte;
      pend_last_r <= in_if.last_of_message;
    end
    if (in_accept && !need_block) begin
      out_data_r <= in_if.data_byte ^ ks_byte;
      out_last_r <= in_if.last_of_message;
    end else if (emit) begin
      out_data_r <= pend_data_r ^ ks_byte;
      out_last_r <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      ctr_init_r  <= '0;
      ctr_r       <= '0;
      pos_r       <= '0;
      start_r     <= 1'b1;
      busy_r      <= 1'b0;
      step_r      <= UC_ENTRY;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY0:     key_r[0]   <= cfg_data;
          CFG_KEY1:     key_r[1]   <= cfg_data;
          CFG_KEY2:     key_r[2]   <= cfg_data;
          CFG_KEY3:     key_r[3]   <= cfg_data;
          CFG_NONCE_LO: nonce_lo_r <= cfg_data;
          CFG_NONCE_HI: nonce_hi_r <= cfg_data[WORD_W-1:0];
          CFG_CTR_INIT: ctr_init_r <= cfg_data[WORD_W-1:0];
          default: begin
          end
        endcase
      end

      if ((in_accept && !need_block) || emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_accept) begin
        start_r <= in_if.last_of_message;
        pos_r   <= in_if.last_of_message ? '0 : POS_W'(pos_eff + 1'b1);
        if (start_r) begin
          ctr_r <= ctr_init_r;
        end
        if (need_block) begin
          busy_r <= 1'b1;
          step_r <= UC_ENTRY;
          rnd_r  <= '0;
        end
      end

      if (busy_r) begin
        if (uc.op == OP_FINAL) begin
          ctr_r <= ctr_r + 1'b1;
        end
        if (uc.op == OP_EMIT) begin
          busy_r <= 1'b0;
          step_r <= UC_ENTRY;
        end else if (uc.loop && rnd_r != RND_LAST) begin
          step_r <= UC_LOOP_START;
          rnd_r  <= rnd_r + 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_if.valid && !busy_r)
    else $error("emit step did not present a result");

  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && uc.op == OP_FINAL) |=> ctr_r == $past(ctr_r) + 32'd1)
    else $error("block counter did not advance after final add");

  a_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !need_block) |=> out_if.valid && !busy_r)
    else $error("mid-block transaction did not produce a result");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && need_block) |=> busy_r && step_r == UC_ENTRY && !out_if.valid)
    else $error("block start did not launch the program");

endmodule

// ===== tb/tb_chacha20_stream_cipher_top.sv =====
module tb_chacha20_stream_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import chacha_pkg::*;

  localparam int ROUNDS = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam logic [WORD_W-1:0] CHACHA_CONST [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };
  // column quarter rounds, then diagonal quarter rounds
  localparam int QR_LANES [8][4] = '{
    '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
  };

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  chacha_in_if  in_ch ();
  chacha_out_if out_ch ();

  chacha20_stream_cipher_top #(
    .DOUBLE_ROUNDS(ROUNDS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  always #5 clk = ~clk;

  // cipher state mirror
  logic [63:0]       key_reg [4];
  logic [63:0]       nonce_lo_reg;
  logic [31:0]       nonce_hi_reg;
  logic [31:0]       ctr_init_reg;
  logic [31:0]       blk_ctr;
  logic [POS_W-1:0]  byte_pos;
  logic              new_msg;
  logic [31:0]       ks_words [16];

  cipher_out_t expected_results [$];
  int mismatch_count = 0;
  int gap_pct = 0;
  int rx_stall_pct = 0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void build_keystream();
    logic [31:0] init [16];
    logic [31:0] w [16];
    int a, b, c, d;
    for (int i = 0; i < 4; i++) init[i] = CHACHA_CONST[i];
    for (int i = 0; i < 8; i++) init[4 + i] = key_reg[i >> 1][32 * (i & 1) +: 32];
    init[12] = blk_ctr;
    init[13] = nonce_lo_reg[31:0];
    init[14] = nonce_lo_reg[63:32];
    init[15] = nonce_hi_reg;
    w = init;
    for (int r = 0; r < ROUNDS; r++) begin
      for (int q = 0; q < 8; q++) begin
        a = QR_LANES[q][0];
        b = QR_LANES[q][1];
        c = QR_LANES[q][2];
        d = QR_LANES[q][3];
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
      end
    end
    for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
  endfunction

  function automatic logic [BYTE_W-1:0] cipher_byte(input logic [BYTE_W-1:0] din,
                                                    input logic last);
    logic [31:0]       ks_word;
    logic [BYTE_W-1:0] ks;
    if (new_msg) begin
      blk_ctr  = ctr_init_reg;
      byte_pos = '0;
      new_msg  = 1'b0;
    end
    if (byte_pos == 0) begin
      build_keystream();
      blk_ctr = blk_ctr + 32'd1;
    end
    ks_word = ks_words[byte_pos[5:2]];
    ks = ks_word[8 * byte_pos[1:0] +: 8];
    byte_pos = byte_pos + 1'b1;
    if (last) begin
      new_msg  = 1'b1;
      byte_pos = '0;
    end
    return din ^ ks;
  endfunction

  function automatic void reset_cipher_state();
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce_lo_reg = '0;
    nonce_hi_reg = '0;
    ctr_init_reg = '0;
    blk_ctr      = '0;
    byte_pos     = '0;
    new_msg      = 1'b1;
    for (int i = 0; i < 16; i++) ks_words[i] = '0;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    cipher_out_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected transaction byte=%02h last=%0b",
                             out_ch.result_byte, out_ch.result_last));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.result_byte !== exp_r.data)
          flag_error($sformatf("result_byte got %02h exp %02h",
                               out_ch.result_byte, exp_r.data));
        if (out_ch.result_last !== exp_r.last)
          flag_error($sformatf("result_last got %0b exp %0b",
                               out_ch.result_last, exp_r.last));
      end
    end
  end

  // receiver with random stall bursts
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(16, 1)) @(posedge clk);
      if ($urandom_range(99) < rx_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    cipher_out_t r;
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.data_byte       <= b;
    in_ch.last_of_message <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r.data = cipher_byte(b, last);
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic send_message(input int len, input bit close);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      // zero bytes expose the raw keystream
      b = ($urandom_range(7) == 0) ? '0 : BYTE_W'($urandom_range(255));
      send_byte(b, close && (i == len - 1));
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_KEY0:     key_reg[0]   = val;
      CFG_KEY1:     key_reg[1]   = val;
      CFG_KEY2:     key_reg[2]   = val;
      CFG_KEY3:     key_reg[3]   = val;
      CFG_NONCE_LO: nonce_lo_reg = val;
      CFG_NONCE_HI: nonce_hi_reg = val[31:0];
      CFG_CTR_INIT: ctr_init_reg = val[31:0];
      default: ;
    endcase
  endtask

  task automatic randomize_config();
    logic [63:0] v;
    for (int i = 0; i <= int'(CFG_CTR_INIT); i++) begin
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(5))
          0:       v = '0;
          1:       v = '1;
          default: v = rand64();
        endcase
        write_reg(CFG_IDX_W'(i), v);
      end
    end
    if ($urandom_range(4) == 0) write_reg(CFG_SPARE, rand64());
  endtask

  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_KEY0, '1);
    write_reg(CFG_KEY1, '1);
    write_reg(CFG_KEY2, '1);
    write_reg(CFG_KEY3, '1);
    write_reg(CFG_NONCE_LO, '1);
    write_reg(CFG_NONCE_HI, '1);
    write_reg(CFG_CTR_INIT, '1);
    // out of range index must leave everything alone
    write_reg(CFG_SPARE, rand64());
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_idle();
    // upper halves of 32-bit registers are dropped
    write_reg(CFG_NONCE_HI, {32'hffff_ffff, 32'h0000_0009});
    write_reg(CFG_CTR_INIT, {32'ha5a5_5a5a, 32'h0000_0001});
    write_reg(CFG_KEY0, '0);
    write_reg(CFG_NONCE_LO, 64'h0000_004a_0000_0000);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_idle();
  endtask

  task automatic test_config_mid_message();
    gap_pct = 20;
    rx_stall_pct = 30;
    write_reg(CFG_KEY1, rand64());
    write_reg(CFG_CTR_INIT, rand64());
    send_message(10, 1'b0);
    wait_idle();
    // key and nonce apply from the next block, counter from the next message
    write_reg(CFG_KEY2, rand64());
    write_reg(CFG_NONCE_HI, rand64());
    write_reg(CFG_CTR_INIT, rand64());
    send_message(60, 1'b1);
    send_message(3, 1'b1);
    wait_idle();
  endtask

  task automatic test_counter_wrap();
    gap_pct = 10;
    rx_stall_pct = 10;
    write_reg(CFG_CTR_INIT, 64'h0000_0000_ffff_ffff);
    send_message(150, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int phase_items;
    int len;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      randomize_config();
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 20;
        default: gap_pct = 50;
      endcase
      rx_stall_pct = 10 * $urandom_range(5);
      phase_items = 0;
      while (phase_items < 100) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(200, 65) : $urandom_range(70, 1);
        // now and then a message stays open across the reconfiguration
        send_message(len, $urandom_range(7) != 0);
        phase_items += len;
      end
      sent += phase_items;
    end
    wait_idle();
  endtask

  task automatic test_steady_stream(input int n_items);
    gap_pct = 0;
    rx_stall_pct = 0;
    randomize_config();
    send_message(n_items - 70, 1'b1);
    send_message(70, 1'b1);
    wait_idle();
  endtask

  initial begin
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.data_byte       <= '0;
    in_ch.last_of_message <= 1'b0;
    reset_cipher_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_extremes();
    test_config_mid_message();
    test_counter_wrap();
    test_random_traffic(780);
    test_steady_stream(150);

    repeat (8 * ROUNDS + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** chacha20_stream_cipher_top: PASSED **");
    end else begin
      $display("** chacha20_stream_cipher_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("** chacha20_stream_cipher_top: FAILED **");
    $finish;
  end

endmodule
